// ===== hdl/route_table_lookup_core_defines.svh =====
// ----------------------------------------------------------------------------
// Route table lookup: assertion macros
// Shared property wrappers for the lookup core.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_LOOKUP_CORE_DEFINES_SVH
`define ROUTE_TABLE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTLU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rtlu_pkg.sv =====
// ----------------------------------------------------------------------------
// Route table lookup package
// Constants, request and response types and shared helpers.
// ----------------------------------------------------------------------------
package rtlu_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PORT_COUNT  = 4;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int IDX_W  = 4;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic MODE_EXACT = 1'b0;
    localparam logic MODE_LPM   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  slot_index;
        logic              slot_valid;
        logic [ADDR_W-1:0] new_prefix;
        logic [ADDR_W-1:0] new_mask;
        logic [ADDR_W-1:0] new_gateway;
        logic [PORT_W-1:0] new_port;
        logic [ADDR_W-1:0] lookup_address;
    } rtlu_req_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  match_index;
        logic [ADDR_W-1:0] next_hop_gateway;
        logic [PORT_W-1:0] out_port;
    } rtlu_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } rtlu_route_t;

    // One table entry as it leaves the read port
    typedef struct packed {
        logic              strobe;
        logic              live;
        logic [SLOT_W-1:0] index;
        rtlu_route_t       route;
    } rtlu_probe_t;

    // Running winner of a scan
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } rtlu_best_t;

    function automatic logic [PORT_W-1:0] clamp_port(input logic [PORT_W-1:0] p);
        logic [PORT_W-1:0] v;
        v = p;
        if (32'(p) >= PORT_COUNT)
        begin
            v = PORT_W'(PORT_COUNT - 1);
        end
        return v;
    endfunction

endpackage

// ===== hdl/route_table_lookup_core.sv =====
// ----------------------------------------------------------------------------
// Route table lookup core
// Routing table with exact or longest-prefix lookup, one entry checked a cycle.
// ----------------------------------------------------------------------------
//  channel   signals                       handshake
//  request   start, busy, req              taken when start && !busy
//  response  done, rsp                     one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data taken when cfg_valid && cfg_ready
//
//  A write request updates the table at the accepting edge; its response
//  strobes the next cycle and busy never rises, so writes run one per cycle.
//  A lookup walks all TABLE_DEPTH slots through the single read port and
//  compare unit, passing through ST_SCAN, ST_LAST and ST_FLUSH before the
//  response strobe; busy falls with the strobe.
//  Reset clears the valid flags and sets longest-prefix mode.
// ----------------------------------------------------------------------------
`include "route_table_lookup_core_defines.svh"

module route_table_lookup_core
    import rtlu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  rtlu_req_t req,
    output logic      done,
    output rtlu_rsp_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FLUSH
    } state_t;

    state_t            state_reg,   state_next;
    logic              busy_reg,    busy_next;
    logic              done_reg,    done_next;
    rtlu_rsp_t         rsp_reg,     rsp_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [ADDR_W-1:0] addr_reg,    addr_next;
    logic              mode_reg,    mode_next;

    logic              accept;
    logic              wr_en;
    logic              clear;
    rtlu_route_t       wr_route;
    rtlu_probe_t       probe;
    rtlu_best_t        best;

    assign accept    = start && !busy_reg;
    assign wr_en     = accept && (req.op == OP_WRITE) && (32'(req.slot_index) < TABLE_DEPTH);
    assign clear     = accept && (req.op == OP_LOOKUP);
    assign cfg_ready = 1'b1;

    assign wr_route.prefix  = req.new_prefix;
    assign wr_route.mask    = req.new_mask;
    assign wr_route.gateway = req.new_gateway;
    assign wr_route.port    = clamp_port(req.new_port);

    rtlu_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_slot  (SLOT_W'(req.slot_index)),
        .wr_live  (req.slot_valid),
        .wr_route (wr_route),
        .rd_en    (state_reg == ST_SCAN),
        .rd_slot  (rd_slot_reg),
        .probe    (probe)
    );

    rtlu_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .mode    (mode_reg),
        .address (addr_reg),
        .probe   (probe),
        .best    (best)
    );

    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        rd_slot_next = rd_slot_reg;
        addr_next    = addr_reg;
        mode_next    = mode_reg;

        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_WRITE)
                    begin
                        done_next                 = 1'b1;
                        rsp_next                  = '0;
                        rsp_next.match_index      = req.slot_index;
                    end
                    else
                    begin
                        addr_next    = req.lookup_address;
                        rd_slot_next = '0;
                        busy_next    = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // advance the read pointer; the last slot leaves for the compare stage
                if (rd_slot_reg == SLOT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    rd_slot_next = rd_slot_reg + SLOT_W'(1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                rsp_next = '0;
                if (best.found)
                begin
                    rsp_next.hit              = 1'b1;
                    rsp_next.match_index      = IDX_W'(best.index);
                    rsp_next.next_hop_gateway = best.gateway;
                    rsp_next.out_port         = best.port;
                end
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
            rd_slot_reg <= '0;
            addr_reg    <= '0;
            mode_reg    <= MODE_LPM;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            rsp_reg     <= rsp_next;
            rd_slot_reg <= rd_slot_next;
            addr_reg    <= addr_next;
            mode_reg    <= mode_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `RTLU_ASSERT_NOW(a_done_not_busy, clk, rst_n, done_reg, !busy_reg,
        "response strobed while busy")
    `RTLU_ASSERT_NEXT(a_lookup_busy, clk, rst_n, clear,
        busy_reg && (state_reg == ST_SCAN), "lookup did not start scan")
    `RTLU_ASSERT_NOW(a_miss_zero, clk, rst_n, done_reg && !rsp_reg.hit,
        (rsp_reg.next_hop_gateway == '0) && (rsp_reg.out_port == '0),
        "miss response not cleared")
    `RTLU_ASSERT_NOW(a_busy_state, clk, rst_n, 1'b1,
        busy_reg == (state_reg != ST_IDLE), "busy out of step with sequencer")

endmodule

// ===== hdl/rtlu_table.sv =====
// ----------------------------------------------------------------------------
// Route table storage
// Entry memory with one write and one registered read port, plus valid flags.
// ----------------------------------------------------------------------------
module rtlu_table
    import rtlu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic              wr_live,
    input  rtlu_route_t       wr_route,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    output rtlu_probe_t       probe
);

    rtlu_route_t             mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  live_reg;
    logic                    strobe_reg;
    logic                    probe_live_reg;
    logic [SLOT_W-1:0]       probe_index_reg;
    rtlu_route_t             probe_route_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_route;
        end
        if (rd_en)
        begin
            probe_route_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg        <= '0;
            strobe_reg      <= 1'b0;
            probe_live_reg  <= 1'b0;
            probe_index_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                live_reg[wr_slot] <= wr_live;
            end
            strobe_reg <= rd_en;
            if (rd_en)
            begin
                probe_live_reg  <= live_reg[rd_slot];
                probe_index_reg <= rd_slot;
            end
        end
    end

    assign probe.strobe = strobe_reg;
    assign probe.live   = probe_live_reg;
    assign probe.index  = probe_index_reg;
    assign probe.route  = probe_route_reg;

endmodule

// ===== hdl/rtlu_match.sv =====
// ----------------------------------------------------------------------------
// Route match unit
// Shared compare unit: checks one entry a cycle and keeps the running winner.
// ----------------------------------------------------------------------------
module rtlu_match
    import rtlu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              mode,
    input  logic [ADDR_W-1:0] address,
    input  rtlu_probe_t       probe,
    output rtlu_best_t        best
);

    logic              found_reg;
    logic [SLOT_W-1:0] index_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [ADDR_W-1:0] gateway_reg;
    logic [PORT_W-1:0] port_reg;
    logic              take;

    // Exact mode keeps the first hit; prefix mode keeps the numerically largest mask, later slot on ties
    always_comb
    begin
        take = 1'b0;
        if (probe.strobe && probe.live)
        begin
            if (mode == MODE_EXACT)
            begin
                take = !found_reg && (probe.route.prefix == address);
            end
            else
            begin
                take = (((address ^ probe.route.prefix) & probe.route.mask) == '0) &&
                       (!found_reg || (probe.route.mask >= mask_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !clear)
        begin
            index_reg   <= probe.index;
            mask_reg    <= probe.route.mask;
            gateway_reg <= probe.route.gateway;
            port_reg    <= probe.route.port;
        end
    end

    assign best.found   = found_reg;
    assign best.index   = index_reg;
    assign best.gateway = gateway_reg;
    assign best.port    = port_reg;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Route table lookup core testbench
// Fills the routing table and looks up addresses in exact and longest-prefix
// mode. An in-bench copy of the table predicts every response; a monitor
// compares each response strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import rtlu_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rtlu_req_t req = '0;
    logic done;
    rtlu_rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    // Shadow of the routing table and the mode register
    logic [ADDR_W-1:0] shadow_prefix [TABLE_DEPTH] = '{default: '0};
    logic [ADDR_W-1:0] shadow_mask [TABLE_DEPTH] = '{default: '0};
    logic [ADDR_W-1:0] shadow_gateway [TABLE_DEPTH] = '{default: '0};
    logic [PORT_W-1:0] shadow_port [TABLE_DEPTH] = '{default: '0};
    logic shadow_valid [TABLE_DEPTH] = '{default: 1'b0};
    logic shadow_mode = MODE_LPM;

    rtlu_rsp_t routes_due[$];
    rtlu_rsp_t due_route;
    int error_count = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b0;
    int calm_left = 0;

    route_table_lookup_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("route_table_lookup_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Apply one request to the shadow table and return its response
    function automatic rtlu_rsp_t resolve_route(input rtlu_req_t r);
        rtlu_rsp_t ans;
        logic found;
        logic [ADDR_W-1:0] best_mask;
        int best;
        ans = '0;
        found = 1'b0;
        best_mask = '0;
        best = 0;
        if (r.op == OP_WRITE)
        begin
            if (int'(r.slot_index) < TABLE_DEPTH)
            begin
                shadow_valid[r.slot_index] = r.slot_valid;
                shadow_prefix[r.slot_index] = r.new_prefix;
                shadow_mask[r.slot_index] = r.new_mask;
                shadow_gateway[r.slot_index] = r.new_gateway;
                shadow_port[r.slot_index] = (int'(r.new_port) >= PORT_COUNT)
                    ? PORT_W'(PORT_COUNT - 1) : r.new_port;
            end
            ans.match_index = r.slot_index;
        end
        else
        begin
            for (int s = 0; s < TABLE_DEPTH; s++)
            begin
                if (!shadow_valid[s])
                    continue;
                if (shadow_mode == MODE_EXACT)
                begin
                    if (!found && shadow_prefix[s] == r.lookup_address)
                    begin
                        found = 1'b1;
                        best = s;
                    end
                end
                else if (((r.lookup_address ^ shadow_prefix[s]) & shadow_mask[s]) == '0
                         && (!found || shadow_mask[s] >= best_mask))
                begin
                    // later slot wins a tie on equal masks
                    found = 1'b1;
                    best = s;
                    best_mask = shadow_mask[s];
                end
            end
            if (found)
            begin
                ans.hit = 1'b1;
                ans.match_index = IDX_W'(best);
                ans.next_hop_gateway = shadow_gateway[best];
                ans.out_port = shadow_port[best];
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (routes_due.size() == 0)
            begin
                report_mismatch($sformatf("response with no request pending: %p", rsp));
            end
            else
            begin
                due_route = routes_due.pop_front();
                if (rsp.hit !== due_route.hit)
                    report_mismatch($sformatf("hit got %b want %b",
                        rsp.hit, due_route.hit));
                if (rsp.match_index !== due_route.match_index)
                    report_mismatch($sformatf("match_index got %0d want %0d",
                        rsp.match_index, due_route.match_index));
                if (rsp.next_hop_gateway !== due_route.next_hop_gateway)
                    report_mismatch($sformatf("next_hop_gateway got %h want %h",
                        rsp.next_hop_gateway, due_route.next_hop_gateway));
                if (rsp.out_port !== due_route.out_port)
                    report_mismatch($sformatf("out_port got %0d want %0d",
                        rsp.out_port, due_route.out_port));
            end
        end
    end

    function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
        return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
    endfunction

    // Unused fields carry random bits
    function automatic rtlu_req_t route_write(input int slot, input logic valid,
        input logic [ADDR_W-1:0] prefix, input logic [ADDR_W-1:0] mask,
        input logic [ADDR_W-1:0] gateway, input logic [PORT_W-1:0] port);
        rtlu_req_t r;
        r.op = OP_WRITE;
        r.slot_index = IDX_W'(slot);
        r.slot_valid = valid;
        r.new_prefix = prefix;
        r.new_mask = mask;
        r.new_gateway = gateway;
        r.new_port = port;
        r.lookup_address = $urandom();
        return r;
    endfunction

    function automatic rtlu_req_t route_lookup(input logic [ADDR_W-1:0] addr);
        rtlu_req_t r;
        r.op = OP_LOOKUP;
        r.slot_index = IDX_W'($urandom_range(0, 15));
        r.slot_valid = 1'($urandom_range(0, 1));
        r.new_prefix = $urandom();
        r.new_mask = $urandom();
        r.new_gateway = $urandom();
        r.new_port = PORT_W'($urandom_range(0, 3));
        r.lookup_address = addr;
        return r;
    endfunction

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drive one request until it is taken, then log its predicted response
    task automatic send_request(input rtlu_req_t item);
        if (gaps_on)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 29) == 0)
                calm_left = $urandom_range(20, 60);
            else if ($urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 17));
        end
        start <= 1'b1;
        req <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        routes_due.push_back(resolve_route(item));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (routes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_match_mode(input logic mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    // Reset leaves longest-prefix mode and an empty table
    task automatic test_empty_table();
        send_request(route_lookup(32'h0000_0000));
        send_request(route_lookup(32'hFFFF_FFFF));
    endtask

    task automatic test_longest_prefix();
        send_request(route_write(0, 1'b1, 32'h0000_0000, 32'h0000_0000,
            32'hFFFF_FFFF, 2'd3));
        send_request(route_write(15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h0000_0001, 2'd0));
        send_request(route_write(5, 1'b1, 32'h0A00_0000, 32'hFF00_0000,
            32'h0A00_0001, 2'd1));
        send_request(route_write(9, 1'b1, 32'h0A01_0000, 32'hFFFF_0000,
            32'h0A01_0001, 2'd2));
        // stored but invalid: lookups must skip it
        send_request(route_write(7, 1'b0, 32'h0A01_0200, 32'hFFFF_FF00,
            32'h0A01_0201, 2'd3));
        send_request(route_lookup(32'h0A01_0203));
        send_request(route_lookup(32'h0A7F_0000));
        send_request(route_lookup(32'hC0A8_0001));
        send_request(route_lookup(32'hFFFF_FFFF));
        // equal mask in a higher slot takes the tie
        send_request(route_write(12, 1'b1, 32'h0A01_0000, 32'hFFFF_0000,
            32'h0A01_000C, 2'd1));
        send_request(route_lookup(32'h0A01_0203));
        // non-contiguous mask compares larger as a number
        send_request(route_write(3, 1'b1, 32'h0A01_AA03, 32'hFFFF_00FF,
            32'h0A01_0003, 2'd2));
        send_request(route_lookup(32'h0A01_0203));
    endtask

    task automatic test_exact_match();
        set_match_mode(MODE_EXACT);
        send_request(route_lookup(32'h0A00_0000));
        // lowest matching slot wins in exact mode
        send_request(route_lookup(32'h0A01_0000));
        send_request(route_lookup(32'h0A01_0203));
        send_request(route_lookup(32'h0A01_0200));
        send_request(route_write(15, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h0000_0001, 2'd0));
        send_request(route_lookup(32'hFFFF_FFFF));
        send_request(route_lookup(32'h0000_0000));
    endtask

    task automatic test_random_traffic(input int count, input logic mode,
        input bit with_gaps);
        rtlu_req_t item;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] addr;
        int s;
        set_match_mode(mode);
        gaps_on = with_gaps;
        calm_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                // mostly contiguous masks over a few shared networks
                mask = ($urandom_range(0, 9) == 0) ? $urandom()
                                                   : prefix_mask($urandom_range(0, 32));
                case ($urandom_range(0, 3))
                    0: prefix = 32'h0A00_0000;
                    1: prefix = 32'hC0A8_0000;
                    2: prefix = 32'hAC10_0000;
                    default: prefix = $urandom();
                endcase
                prefix = (prefix & mask) | ($urandom() & ~mask);
                item = route_write($urandom_range(0, 15),
                    1'($urandom_range(0, 9) != 0), prefix, mask, $urandom(),
                    PORT_W'($urandom_range(0, 3)));
            end
            else
            begin
                s = $urandom_range(0, 15);
                if ($urandom_range(0, 9) < 3)
                    addr = $urandom();
                else if (mode == MODE_EXACT)
                    addr = shadow_prefix[s];
                else
                    addr = (shadow_prefix[s] & shadow_mask[s]) | ($urandom() & ~shadow_mask[s]);
                item = route_lookup(addr);
            end
            send_request(item);
        end
        gaps_on = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_longest_prefix();
        test_exact_match();
        test_random_traffic(300, MODE_LPM, 1'b1);
        test_random_traffic(250, MODE_EXACT, 1'b1);
        test_random_traffic(300, MODE_LPM, 1'b1);
        test_random_traffic(100, MODE_EXACT, 1'b0);
        test_random_traffic(150, MODE_LPM, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && routes_due.size() == 0)
            $display("route_table_lookup_core test passed");
        else
            $display("route_table_lookup_core test failed");
        $finish;
    end

endmodule
